// ===== hw/rtl/u2da_pkg.sv =====
package u2da_pkg;

    localparam int VALUE_W   = 64;
    localparam int DIGITS    = 20;
    localparam int BCD_W     = DIGITS * 4;
    localparam int TOTAL_W   = 5;
    localparam int IDX_W     = 5;
    localparam int CHAR_W    = 6;
    localparam int STEP_BITS = 4;
    localparam int STEPS     = VALUE_W / STEP_BITS;
    localparam int STEP_CNT_W = $clog2(STEPS);

    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PUSH
    } t_conv_state;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [TOTAL_W-1:0] total;
    } t_entry;

    // One double-dabble bit step: correct every BCD digit, then shift in one bit.
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] b,
                                                 input logic bit_in);
        logic [BCD_W-1:0] a;
        a = b;
        for (int i = 0; i < DIGITS; i++) begin
            if (b[i*4 +: 4] >= 4'd5) begin
                a[i*4 +: 4] = b[i*4 +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    function automatic logic [TOTAL_W-1:0] count_digits(input logic [BCD_W-1:0] b);
        logic [TOTAL_W-1:0] t;
        t = TOTAL_W'(1);
        for (int k = 1; k < DIGITS; k++) begin
            if (b[k*4 +: 4] != 4'd0) begin
                t = TOTAL_W'(k + 1);
            end
        end
        return t;
    endfunction

endpackage

// ===== hw/rtl/u2da_conv.sv =====
module u2da_conv (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [u2da_pkg::VALUE_W-1:0] i_value,
    output logic                     o_busy,
    input  logic                     i_full,
    output logic                     o_push,
    output u2da_pkg::t_entry         o_entry
);

    u2da_pkg::t_conv_state r_state, n_state;
    logic [u2da_pkg::VALUE_W-1:0]    r_bin, n_bin;
    logic [u2da_pkg::BCD_W-1:0]      r_bcd, n_bcd;
    logic [u2da_pkg::STEP_CNT_W-1:0] r_cnt, n_cnt;
    logic [u2da_pkg::BCD_W-1:0]      step_bcd;
    logic                            accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u2da_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
    end

    always_comb begin
        step_bcd = r_bcd;
        for (int j = 0; j < u2da_pkg::STEP_BITS; j++) begin
            step_bcd = u2da_pkg::dd_step(step_bcd,
                                         r_bin[u2da_pkg::VALUE_W-1-j]);
        end
    end

    always_comb begin
        n_state       = r_state;
        n_bin         = r_bin;
        n_bcd         = r_bcd;
        n_cnt         = r_cnt;
        o_busy        = 1'b1;
        o_push        = 1'b0;
        o_entry.bcd   = r_bcd;
        o_entry.total = u2da_pkg::count_digits(r_bcd);
        case (r_state)
            u2da_pkg::S_IDLE: begin
                o_busy = 1'b0;
            end
            u2da_pkg::S_CONV: begin
                n_bin = r_bin << u2da_pkg::STEP_BITS;
                n_bcd = step_bcd;
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == u2da_pkg::STEP_CNT_W'(u2da_pkg::STEPS - 1)) begin
                    n_state = u2da_pkg::S_PUSH;
                end
            end
            u2da_pkg::S_PUSH: begin
                if (!i_full) begin
                    o_push  = 1'b1;
                    o_busy  = 1'b0;
                    n_state = u2da_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = u2da_pkg::S_IDLE;
            end
        endcase
        accept = i_start && !o_busy;
        if (accept) begin
            n_state = u2da_pkg::S_CONV;
            n_bin   = i_value;
            n_bcd   = '0;
            n_cnt   = '0;
        end
    end

endmodule

// ===== hw/rtl/u2da_fifo.sv =====
module u2da_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u2da_pkg::t_entry i_entry,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output u2da_pkg::t_entry o_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2da_pkg::t_entry    r_mem [DEPTH];
    logic [PTR_W-1:0]    r_wr, n_wr;
    logic [PTR_W-1:0]    r_rd, n_rd;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (i_pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

// ===== hw/rtl/u2da_emit.sv =====
module u2da_emit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    input  u2da_pkg::t_entry              i_entry,
    output logic                          o_pop,
    output logic                          o_valid,
    output logic [u2da_pkg::CHAR_W-1:0]   o_digit_char,
    output logic [u2da_pkg::TOTAL_W-1:0]  o_digit_total,
    output logic                          o_is_last
);

    logic                          r_active, n_active;
    logic [u2da_pkg::IDX_W-1:0]    r_idx, n_idx;
    logic [u2da_pkg::BCD_W-1:0]    r_bcd, n_bcd;
    logic [u2da_pkg::TOTAL_W-1:0]  r_total, n_total;
    logic                          last;

    assign last          = (r_idx == '0);
    assign o_valid       = r_active;
    assign o_is_last     = last;
    assign o_digit_total = r_total;
    assign o_digit_char  = u2da_pkg::ASCII_ZERO + {2'b00, r_bcd[r_idx*4 +: 4]};

    always_comb begin
        o_pop    = !i_empty && (!r_active || last);
        n_active = r_active && !last;
        n_idx    = r_idx - 1'b1;
        n_bcd    = r_bcd;
        n_total  = r_total;
        if (o_pop) begin
            n_active = 1'b1;
            n_bcd    = i_entry.bcd;
            n_total  = i_entry.total;
            n_idx    = u2da_pkg::IDX_W'(i_entry.total - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else begin
            r_active <= n_active;
        end
        r_idx   <= n_idx;
        r_bcd   <= n_bcd;
        r_total <= n_total;
    end

endmodule

// ===== hw/rtl/u64_to_decimal_ascii.sv =====
// Unsigned 64-bit value to decimal ASCII text.
// Input: drive i_value and raise i_start; the beat is taken at a clock edge
// where i_start is high and o_busy is low.
// Output: one beat per decimal digit, most significant first, with no
// leading zeros (zero gives a single '0'). Each beat is shown for exactly
// one cycle with o_valid high and carries the ASCII digit, the total digit
// count of the value and o_is_last on the final digit.
// The front converter runs a double-dabble loop that takes four bits per
// cycle, then queues the value from a push state that waits while the
// queue is full; the next value can be taken in the same cycle as the
// push. The back end emits one digit per cycle. Intake is limited by the
// conversion loop for short numbers and by the one-digit-per-cycle output
// for long ones. A queue of QUEUE_DEPTH converted values sits between the
// two parts. The receiver cannot stall the output.
// Reset (synchronous, active low) drops any value in flight and clears the
// queue; no beat is shown during reset.
module u64_to_decimal_ascii #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [u2da_pkg::VALUE_W-1:0]  i_value,
    output logic                          o_busy,
    output logic                          o_valid,
    output logic [u2da_pkg::CHAR_W-1:0]   o_digit_char,
    output logic [u2da_pkg::TOTAL_W-1:0]  o_digit_total,
    output logic                          o_is_last
);

    logic             full, empty, push, pop;
    u2da_pkg::t_entry push_entry, pop_entry;

    u2da_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_value (i_value),
        .o_busy  (o_busy),
        .i_full  (full),
        .o_push  (push),
        .o_entry (push_entry)
    );

    u2da_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_entry (pop_entry)
    );

    u2da_emit u_emit (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_entry       (pop_entry),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_digit_char  (o_digit_char),
        .o_digit_total (o_digit_total),
        .o_is_last     (o_is_last)
    );

endmodule

// ===== hw/rtl/u2da_chk.sv =====
module u2da_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_start,
    input logic                          o_busy,
    input logic                          o_valid,
    input logic [u2da_pkg::TOTAL_W-1:0]  o_digit_total,
    input logic                          o_is_last
);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy)
        else $error("no busy cycle after a value was taken");

    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |=> o_valid)
        else $error("digit run broken before its last beat");

    a_total_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_last |=> o_digit_total == $past(o_digit_total))
        else $error("digit count changed within a run");

    a_single_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_digit_total == 5'd1 |-> o_is_last)
        else $error("one-digit value not marked last");

    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("beat shown straight after reset");

endmodule

bind u64_to_decimal_ascii u2da_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_start       (i_start),
    .o_busy        (o_busy),
    .o_valid       (o_valid),
    .o_digit_total (o_digit_total),
    .o_is_last     (o_is_last)
);

// ===== dv/tb.sv =====
module tb;

    localparam int N_RANDOM    = 400;
    localparam int DRAIN_LIMIT = 40;

    typedef struct {
        logic [u2da_pkg::CHAR_W-1:0]  digit_char;
        logic [u2da_pkg::TOTAL_W-1:0] digit_total;
        logic                         is_last;
    } t_digit_beat;

    logic                           i_clk   = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_start = 1'b0;
    logic [u2da_pkg::VALUE_W-1:0]   i_value = '0;
    logic                           o_busy;
    logic                           o_valid;
    logic [u2da_pkg::CHAR_W-1:0]    o_digit_char;
    logic [u2da_pkg::TOTAL_W-1:0]   o_digit_total;
    logic                           o_is_last;

    t_digit_beat                    pending_digits[$];
    t_digit_beat                    want_beat;
    logic [u2da_pkg::VALUE_W-1:0]   ten_pow [u2da_pkg::DIGITS];
    logic [u2da_pkg::VALUE_W-1:0]   table_value[$];
    string                          table_text[$];
    int                             fail_count = 0;

    u64_to_decimal_ascii dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .i_value       (i_value),
        .o_busy        (o_busy),
        .o_valid       (o_valid),
        .o_digit_char  (o_digit_char),
        .o_digit_total (o_digit_total),
        .o_is_last     (o_is_last)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Splits the value into decimal digits and queues one beat per digit,
    // most significant first, with leading zeros dropped.
    function automatic void predict_digits(input logic [63:0] v);
        logic [3:0]  rev [u2da_pkg::DIGITS];
        logic [63:0] rest;
        int          count;
        t_digit_beat beat;
        rest  = v;
        count = 1;
        for (int k = 0; k < u2da_pkg::DIGITS; k++) begin
            rev[k] = 4'(rest % 64'd10);
            rest   = rest / 64'd10;
        end
        for (int k = 1; k < u2da_pkg::DIGITS; k++) begin
            if (rev[k] != 4'd0) begin
                count = k + 1;
            end
        end
        for (int k = 0; k < count; k++) begin
            beat.digit_char  = u2da_pkg::ASCII_ZERO + u2da_pkg::CHAR_W'(rev[count-1-k]);
            beat.digit_total = u2da_pkg::TOTAL_W'(count);
            beat.is_last     = (k == count - 1);
            pending_digits.push_back(beat);
        end
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(10, 60);
    endfunction

    // An empty text means the expected digits come from the predictor.
    task automatic send_value(input logic [63:0] v, input string text);
        t_digit_beat beat;
        i_start <= 1'b1;
        i_value <= v;
        do @(posedge i_clk); while (o_busy);
        if (text.len() == 0) begin
            predict_digits(v);
        end else begin
            for (int k = 0; k < text.len(); k++) begin
                beat.digit_char  = u2da_pkg::CHAR_W'(text[k]);
                beat.digit_total = u2da_pkg::TOTAL_W'(text.len());
                beat.is_last     = (k == text.len() - 1);
                pending_digits.push_back(beat);
            end
        end
    endtask

    task automatic idle_gap(input int cycles);
        if (cycles > 0) begin
            i_start <= 1'b0;
            i_value <= rand64();
            repeat (cycles) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] random_value();
        int          n;
        logic [63:0] lo;
        logic [63:0] hi;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                n  = $urandom_range(1, u2da_pkg::DIGITS);
                lo = (n == 1) ? 64'd0 : ten_pow[n-1];
                hi = (n == u2da_pkg::DIGITS) ? '1 : ten_pow[n] - 64'd1;
                return lo + rand64() % (hi - lo + 64'd1);
            end
            6, 7: begin
                return rand64() >> $urandom_range(0, 63);
            end
            8: begin
                return rand64();
            end
            default: begin
                return ten_pow[$urandom_range(0, u2da_pkg::DIGITS - 1)]
                       + 64'($urandom_range(0, 2)) - 64'd1;
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_digits.size() == 0) begin
                $error("digit beat %0d with no expectation pending", o_digit_char);
                fail_count++;
            end else begin
                want_beat = pending_digits.pop_front();
                if (o_digit_char !== want_beat.digit_char) begin
                    $error("digit_char: expected %0d, got %0d",
                           want_beat.digit_char, o_digit_char);
                    fail_count++;
                end
                if (o_digit_total !== want_beat.digit_total) begin
                    $error("digit_total: expected %0d, got %0d",
                           want_beat.digit_total, o_digit_total);
                    fail_count++;
                end
                if (o_is_last !== want_beat.is_last) begin
                    $error("is_last: expected %0d, got %0d",
                           want_beat.is_last, o_is_last);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        ten_pow[0] = 64'd1;
        for (int k = 1; k < u2da_pkg::DIGITS; k++) begin
            ten_pow[k] = ten_pow[k-1] * 64'd10;
        end

        table_value = '{
            64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 64'd1, 64'd9, 64'd10, 64'd9999, 64'd10000,
            64'd99999999, 64'd100000000, 64'd9999999999999999, 64'd10000000000000000,
            64'd4294967295, 64'd4294967296, 64'd42949672960, 64'd109951163,
            64'd9999999999999999999, 64'd10000000000000000000,
            64'h8000_0000_0000_0000, 64'd12345678901234567890,
            64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
            64'h0123_4567_89AB_CDEF, 64'd1234567
        };
        table_text = '{
            "0", "18446744073709551615", "1", "9", "10", "9999", "10000",
            "99999999", "100000000", "9999999999999999", "10000000000000000",
            "4294967295", "4294967296", "42949672960", "109951163",
            "9999999999999999999", "10000000000000000000",
            "9223372036854775808", "12345678901234567890",
            "", "", "", ""
        };

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (table_value[r]) begin
            send_value(table_value[r], table_text[r]);
            idle_gap(pick_gap());
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            send_value(random_value(), "");
            // Every hundred values the first thirty go back to back.
            if (n % 100 >= 30) begin
                idle_gap(pick_gap());
            end
            if (n == N_RANDOM / 2) begin
                idle_gap(1);
                while (pending_digits.size() != 0) @(posedge i_clk);
            end
        end
        i_start <= 1'b0;

        while (pending_digits.size() != 0) @(posedge i_clk);
        repeat (DRAIN_LIMIT) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== u64_to_decimal_ascii.f =====
hw/rtl/u2da_pkg.sv
hw/rtl/u2da_conv.sv
hw/rtl/u2da_fifo.sv
hw/rtl/u2da_emit.sv
hw/rtl/u64_to_decimal_ascii.sv
hw/rtl/u2da_chk.sv
dv/tb.sv
